// ----- sv/u8df_pkg.sv -----
// Shared types, character codes and fold tables for the UTF-8 digraph fold stream.
package u8df_pkg;

	localparam int RES_MAX = 5;
	localparam int CNT_W   = 3;
	localparam int QDEPTH  = 4;
	localparam int QAW     = 2;
	localparam int CODE_W  = 21;
	localparam int PART_W  = 15;
	localparam int N_APOS  = 9;

	localparam logic [7:0] CH_S_LO = 8'h73;
	localparam logic [7:0] CH_S_UP = 8'h53;
	localparam logic [7:0] CH_C_LO = 8'h63;
	localparam logic [7:0] CH_C_UP = 8'h43;
	localparam logic [7:0] CH_O_LO = 8'h6F;
	localparam logic [7:0] CH_O_UP = 8'h4F;
	localparam logic [7:0] CH_G_LO = 8'h67;
	localparam logic [7:0] CH_G_UP = 8'h47;
	localparam logic [7:0] CH_H_LO = 8'h68;
	localparam logic [7:0] CH_H_UP = 8'h48;

	localparam logic [15:0] FOLD_S_LO = 16'hC59F;
	localparam logic [15:0] FOLD_S_UP = 16'hC59E;
	localparam logic [15:0] FOLD_C_LO = 16'hC3A7;
	localparam logic [15:0] FOLD_C_UP = 16'hC387;
	localparam logic [15:0] FOLD_O_LO = 16'hC3B6;
	localparam logic [15:0] FOLD_O_UP = 16'hC396;
	localparam logic [15:0] FOLD_G_LO = 16'hC49F;
	localparam logic [15:0] FOLD_G_UP = 16'hC49E;

	localparam logic [CODE_W-1:0] APOS [N_APOS] = '{
		21'h00027, 21'h00060, 21'h000B4, 21'h002B9, 21'h002BB,
		21'h002BC, 21'h02018, 21'h02019, 21'h02032
	};

	typedef struct packed {
		logic [RES_MAX-1:0][7:0] bytes;
		logic [CNT_W-1:0]        cnt;
		logic                    eot;
	} rec_t;

	function automatic logic [CODE_W-1:0] ext_ch(input logic [7:0] ch);
		return {{(CODE_W-8){1'b0}}, ch};
	endfunction

	function automatic logic is_starter(input logic [CODE_W-1:0] c);
		return c == ext_ch(CH_S_LO) || c == ext_ch(CH_S_UP) ||
		       c == ext_ch(CH_C_LO) || c == ext_ch(CH_C_UP) ||
		       c == ext_ch(CH_O_LO) || c == ext_ch(CH_O_UP) ||
		       c == ext_ch(CH_G_LO) || c == ext_ch(CH_G_UP);
	endfunction

	function automatic logic [15:0] fold_pair(input logic [7:0] first,
		input logic [CODE_W-1:0] second);
		logic lh;
		logic anyh;
		logic ap;
		logic [15:0] r;
		lh   = second == ext_ch(CH_H_LO);
		anyh = lh || second == ext_ch(CH_H_UP);
		ap   = 1'b0;
		for (int k = 0; k < N_APOS; k++) begin
			if (second == APOS[k]) begin
				ap = 1'b1;
			end
		end
		unique case (first)
			CH_S_LO: r = lh   ? FOLD_S_LO : 16'h0000;
			CH_S_UP: r = anyh ? FOLD_S_UP : 16'h0000;
			CH_C_LO: r = lh   ? FOLD_C_LO : 16'h0000;
			CH_C_UP: r = anyh ? FOLD_C_UP : 16'h0000;
			CH_O_LO: r = ap   ? FOLD_O_LO : 16'h0000;
			CH_O_UP: r = ap   ? FOLD_O_UP : 16'h0000;
			CH_G_LO: r = ap   ? FOLD_G_LO : 16'h0000;
			CH_G_UP: r = ap   ? FOLD_G_UP : 16'h0000;
			default: r = 16'h0000;
		endcase
		return r;
	endfunction

endpackage

// ----- sv/u8df_front.sv -----
// Front end: decodes input bytes, folds digraphs and builds one output record per byte.
module u8df_front import u8df_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	input  logic       q_full,
	output logic       push,
	output rec_t       rec
);

	logic [7:0]        pend_q;
	logic [7:0]        pend_d;
	logic [7:0]        seq_b_q [3];
	logic [7:0]        seq_b_d [3];
	logic [1:0]        seq_cnt_q;
	logic [1:0]        seq_cnt_d;
	logic [2:0]        seq_len_q;
	logic [2:0]        seq_len_d;
	logic [PART_W-1:0] part_q;
	logic [PART_W-1:0] part_d;
	logic              accept;
	rec_t              rec_d;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		logic [CODE_W-1:0] code;
		logic [CODE_W-1:0] f_code;
		logic [7:0]        raw [4];
		logic [2:0]        f_n;
		logic              f_en;
		logic              start;
		logic              abort;
		logic [15:0]       f_pair;
		pend_d    = pend_q;
		seq_b_d   = seq_b_q;
		seq_cnt_d = seq_cnt_q;
		seq_len_d = seq_len_q;
		part_d    = part_q;
		rec_d     = '0;
		rec_d.eot = end_of_text;
		code      = {part_q, in_byte[5:0]};
		f_code    = '0;
		f_n       = '0;
		f_en      = 1'b0;
		start     = 1'b0;
		abort     = 1'b0;
		f_pair    = '0;
		raw       = '{default: in_byte};
		for (int k = 0; k < 3; k++) begin
			if (2'(k) < seq_cnt_q) begin
				raw[k] = seq_b_q[k];
			end
		end

		if (seq_cnt_q != 2'd0) begin
			if (in_byte[7:6] == 2'b10) begin
				if (({1'b0, seq_cnt_q} + 3'd1 >= seq_len_q) || (seq_cnt_q == 2'd3)) begin
					f_en      = 1'b1;
					f_code    = code;
					f_n       = {1'b0, seq_cnt_q} + 3'd1;
					seq_cnt_d = '0;
					seq_len_d = '0;
					part_d    = '0;
				end else begin
					seq_b_d[seq_cnt_q] = in_byte;
					seq_cnt_d          = seq_cnt_q + 2'd1;
					part_d             = code[PART_W-1:0];
				end
			end else begin
				abort = 1'b1;
				start = 1'b1;
			end
		end else begin
			start = 1'b1;
		end

		// release the pending letter, then the held bytes raw
		if (abort) begin
			if (pend_d != 8'd0) begin
				rec_d.bytes[rec_d.cnt] = pend_d;
				rec_d.cnt              = rec_d.cnt + 3'd1;
			end
			pend_d = '0;
			for (int k = 0; k < 3; k++) begin
				if (2'(k) < seq_cnt_q) begin
					rec_d.bytes[rec_d.cnt] = seq_b_q[k];
					rec_d.cnt              = rec_d.cnt + 3'd1;
				end
			end
			seq_cnt_d = '0;
			seq_len_d = '0;
			part_d    = '0;
		end

		if (start) begin
			if (!in_byte[7]) begin
				f_en   = 1'b1;
				f_code = ext_ch(in_byte);
				f_n    = 3'd1;
				raw[0] = in_byte;
			end else if (in_byte[7:5] == 3'b110) begin
				seq_b_d[0] = in_byte;
				seq_cnt_d  = 2'd1;
				seq_len_d  = 3'd2;
				part_d     = {{(PART_W-5){1'b0}}, in_byte[4:0]};
			end else if (in_byte[7:4] == 4'b1110) begin
				seq_b_d[0] = in_byte;
				seq_cnt_d  = 2'd1;
				seq_len_d  = 3'd3;
				part_d     = {{(PART_W-4){1'b0}}, in_byte[3:0]};
			end else if (in_byte[7:3] == 5'b11110) begin
				seq_b_d[0] = in_byte;
				seq_cnt_d  = 2'd1;
				seq_len_d  = 3'd4;
				part_d     = {{(PART_W-3){1'b0}}, in_byte[2:0]};
			end else begin
				f_en   = 1'b1;
				f_code = '0;
				f_n    = 3'd1;
				raw[0] = in_byte;
			end
		end

		if (f_en) begin
			f_pair = fold_pair(pend_d, f_code);
			if (f_pair != 16'h0000) begin
				rec_d.bytes[rec_d.cnt] = f_pair[15:8];
				rec_d.cnt              = rec_d.cnt + 3'd1;
				rec_d.bytes[rec_d.cnt] = f_pair[7:0];
				rec_d.cnt              = rec_d.cnt + 3'd1;
				pend_d                 = '0;
			end else begin
				if (pend_d != 8'd0) begin
					rec_d.bytes[rec_d.cnt] = pend_d;
					rec_d.cnt              = rec_d.cnt + 3'd1;
				end
				pend_d = '0;
				if (is_starter(f_code)) begin
					pend_d = f_code[7:0];
				end else begin
					for (int k = 0; k < 4; k++) begin
						if (3'(k) < f_n) begin
							rec_d.bytes[rec_d.cnt] = raw[k];
							rec_d.cnt              = rec_d.cnt + 3'd1;
						end
					end
				end
			end
		end

		// flush the open sequence and the pending letter
		if (end_of_text) begin
			if (seq_cnt_d != 2'd0) begin
				if (pend_d != 8'd0) begin
					rec_d.bytes[rec_d.cnt] = pend_d;
					rec_d.cnt              = rec_d.cnt + 3'd1;
				end
				pend_d = '0;
				for (int k = 0; k < 3; k++) begin
					if (2'(k) < seq_cnt_d) begin
						rec_d.bytes[rec_d.cnt] = seq_b_d[k];
						rec_d.cnt              = rec_d.cnt + 3'd1;
					end
				end
			end
			if (pend_d != 8'd0) begin
				rec_d.bytes[rec_d.cnt] = pend_d;
				rec_d.cnt              = rec_d.cnt + 3'd1;
			end
			pend_d    = '0;
			seq_cnt_d = '0;
			seq_len_d = '0;
			part_d    = '0;
		end
	end

	assign push = accept && (rec_d.cnt != '0);
	assign rec  = rec_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			seq_cnt_q <= '0;
			seq_len_q <= '0;
			part_q    <= '0;
		end else if (accept) begin
			pend_q    <= pend_d;
			seq_cnt_q <= seq_cnt_d;
			seq_len_q <= seq_len_d;
			part_q    <= part_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seq_b_q <= seq_b_d;
		end
	end

	a_rec_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (rec.cnt <= CNT_W'(RES_MAX)))
		else $error("record holds more beats than allowed");

	a_eot_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_text) |=> (pend_q == 8'd0) && (seq_cnt_q == 2'd0))
		else $error("state not cleared after end of text");

	a_eot_push: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_text) |-> push)
		else $error("end of text produced no beat");

endmodule

// ----- sv/u8df_queue.sv -----
// Record queue between the decoding front end and the beat serializer.
module u8df_queue import u8df_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t wr_rec,
	input  logic pop,
	output logic full,
	output logic q_valid,
	output rec_t rd_rec
);

	rec_t             mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     cnt_q;

	assign full    = cnt_q == (QAW+1)'(QDEPTH);
	assign q_valid = cnt_q != '0;
	assign rd_rec  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (QAW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QAW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("write into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("read from empty queue");

endmodule

// ----- sv/u8df_back.sv -----
// Back end: sends the bytes of each queued record one beat at a time.
module u8df_back import u8df_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  rec_t       q_rec,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       text_last
);

	logic [CNT_W-1:0] idx_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             run_last_q;
	logic             text_last_q;
	logic             load;
	logic             last_beat;

	assign last_beat = idx_q == (q_rec.cnt - 3'd1);
	assign load      = q_valid && (!out_valid_q || out_ready);
	assign pop       = load && last_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last_beat ? '0 : idx_q + 3'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q  <= q_rec.bytes[idx_q];
			run_last_q  <= last_beat;
			text_last_q <= last_beat && q_rec.eot;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;
	assign text_last = text_last_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> (idx_q < q_rec.cnt))
		else $error("beat index past record length");

endmodule

// ----- sv/utf8_digraph_fold_stream_top.sv -----
// Top level of the UTF-8 digraph fold stream.
// Takes one UTF-8 byte per cycle whenever the four-record queue between the
// decoder and the serializer has room. Each accepted byte yields zero to five
// output beats (held letters and open multi-byte sequences yield none until
// resolved); the serializer sends one beat per cycle while out_ready is
// high, so sustained throughput is one output beat per cycle. A byte's
// first beat is held in a queue entry, then in the output register.
// run_last marks each byte's last beat, text_last the text's final beat.
module utf8_digraph_fold_stream_top import u8df_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       text_last
);

	logic q_full;
	logic push;
	logic pop;
	logic q_valid;
	rec_t wr_rec;
	rec_t rd_rec;

	u8df_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.q_full      (q_full),
		.push        (push),
		.rec         (wr_rec)
	);

	u8df_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_rec  (wr_rec),
		.pop     (pop),
		.full    (q_full),
		.q_valid (q_valid),
		.rd_rec  (rd_rec)
	);

	u8df_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_rec     (rd_rec),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.text_last (text_last)
	);

endmodule

// ----- dv/u8df_checker.sv -----
`timescale 1ns / 1ps
// Checker for the UTF-8 digraph fold stream: predicts the output beats and compares them.
module u8df_checker import u8df_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic       run_last,
	input  logic       text_last,
	output int         mismatches,
	output int         beats_owed
);

	typedef struct packed {
		logic [7:0] data;
		logic       run_end;
		logic       text_end;
	} beat_t;

	logic [7:0]        held_letter;
	logic [7:0]        seq_buf [3];
	logic [1:0]        seq_cnt;
	logic [2:0]        seq_len;
	logic [CODE_W-1:0] code_acc;
	beat_t             step_beats [$];
	beat_t             owed_beats [$];
	beat_t             got_beat;
	beat_t             want_beat;

	function automatic logic is_apostrophe(input logic [CODE_W-1:0] c);
		for (int k = 0; k < N_APOS; k++) begin
			if (c == APOS[k]) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic holds_back(input logic [CODE_W-1:0] c);
		if (c[CODE_W-1:8] != '0) begin
			return 1'b0;
		end
		case (c[7:0])
			CH_S_LO, CH_S_UP, CH_C_LO, CH_C_UP,
			CH_O_LO, CH_O_UP, CH_G_LO, CH_G_UP: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [15:0] folded_pair(input logic [7:0] first,
			input logic [CODE_W-1:0] nxt);
		logic lower_h;
		logic either_h;
		logic apo;
		lower_h  = nxt == {13'd0, CH_H_LO};
		either_h = lower_h || nxt == {13'd0, CH_H_UP};
		apo      = is_apostrophe(nxt);
		case (first)
			CH_S_LO: return lower_h  ? FOLD_S_LO : 16'h0000;
			CH_S_UP: return either_h ? FOLD_S_UP : 16'h0000;
			CH_C_LO: return lower_h  ? FOLD_C_LO : 16'h0000;
			CH_C_UP: return either_h ? FOLD_C_UP : 16'h0000;
			CH_O_LO: return apo      ? FOLD_O_LO : 16'h0000;
			CH_O_UP: return apo      ? FOLD_O_UP : 16'h0000;
			CH_G_LO: return apo      ? FOLD_G_LO : 16'h0000;
			CH_G_UP: return apo      ? FOLD_G_UP : 16'h0000;
			default: return 16'h0000;
		endcase
	endfunction

	task automatic emit(input logic [7:0] b);
		step_beats.push_back({b, 1'b0, 1'b0});
	endtask

	task automatic pass_char(input logic [CODE_W-1:0] c, input logic [31:0] raw, input int n);
		logic [15:0] f;
		if (held_letter != 8'h00) begin
			f = folded_pair(held_letter, c);
			if (f != 16'h0000) begin
				held_letter = 8'h00;
				emit(f[15:8]);
				emit(f[7:0]);
				return;
			end
			emit(held_letter);
			held_letter = 8'h00;
		end
		if (holds_back(c)) begin
			held_letter = c[7:0];
			return;
		end
		for (int k = 0; k < n; k++) begin
			emit(raw[31-8*k -: 8]);
		end
	endtask

	task automatic clear_seq;
		seq_cnt  = 2'd0;
		seq_len  = 3'd0;
		code_acc = '0;
	endtask

	task automatic clear_state;
		held_letter = 8'h00;
		seq_buf     = '{8'h00, 8'h00, 8'h00};
		clear_seq();
	endtask

	task automatic drop_seq;
		for (int k = 0; k < seq_cnt; k++) begin
			pass_char('0, {seq_buf[k], 24'd0}, 1);
		end
		clear_seq();
	endtask

	task automatic take_lead(input logic [7:0] b);
		if (b < 8'h80) begin
			pass_char({13'd0, b}, {b, 24'd0}, 1);
		end else if ((b & 8'hE0) == 8'hC0) begin
			seq_buf[0] = b;
			seq_cnt    = 2'd1;
			seq_len    = 3'd2;
			code_acc   = {16'd0, b[4:0]};
		end else if ((b & 8'hF0) == 8'hE0) begin
			seq_buf[0] = b;
			seq_cnt    = 2'd1;
			seq_len    = 3'd3;
			code_acc   = {17'd0, b[3:0]};
		end else if ((b & 8'hF8) == 8'hF0) begin
			seq_buf[0] = b;
			seq_cnt    = 2'd1;
			seq_len    = 3'd4;
			code_acc   = {18'd0, b[2:0]};
		end else begin
			pass_char('0, {b, 24'd0}, 1);
		end
	endtask

	task automatic fold_byte(input logic [7:0] b, input logic eot);
		logic [CODE_W-1:0] nxt;
		logic [31:0]       raw;
		int                n;
		beat_t             tail;
		step_beats.delete();
		if (seq_cnt != 2'd0) begin
			if (b[7:6] == 2'b10) begin
				nxt = {code_acc[CODE_W-7:0], b[5:0]};
				if (seq_cnt + 1 >= seq_len || seq_cnt >= 3) begin
					raw = {seq_buf[0], seq_buf[1], seq_buf[2], 8'h00};
					n   = seq_cnt;
					raw[31-8*n -: 8] = b;
					clear_seq();
					pass_char(nxt, raw, n + 1);
				end else begin
					seq_buf[seq_cnt] = b;
					seq_cnt          = seq_cnt + 2'd1;
					code_acc         = nxt;
				end
			end else begin
				drop_seq();
				take_lead(b);
			end
		end else begin
			take_lead(b);
		end
		if (eot) begin
			if (seq_cnt != 2'd0) begin
				drop_seq();
			end
			if (held_letter != 8'h00) begin
				emit(held_letter);
			end
			clear_state();
		end
		if (step_beats.size() > 0) begin
			tail          = step_beats.pop_back();
			tail.run_end  = 1'b1;
			tail.text_end = eot;
			step_beats.push_back(tail);
		end
		foreach (step_beats[k]) begin
			owed_beats.push_back(step_beats[k]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			owed_beats.delete();
			mismatches = 0;
			beats_owed = 0;
		end else begin
			if (out_valid && out_ready) begin
				got_beat = {out_byte, run_last, text_last};
				if (owed_beats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected beat: byte %h run_last %b text_last %b",
							got_beat.data, got_beat.run_end, got_beat.text_end);
					end
				end else begin
					want_beat = owed_beats.pop_front();
					if (want_beat !== got_beat) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected %h/%b/%b, got %h/%b/%b",
								want_beat.data, want_beat.run_end, want_beat.text_end,
								got_beat.data, got_beat.run_end, got_beat.text_end);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				fold_byte(in_byte, end_of_text);
			end
			beats_owed = owed_beats.size();
		end
	end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Testbench top for the UTF-8 digraph fold stream: drives byte texts and gives the verdict.
module testbench import u8df_pkg::*;;

	localparam logic [7:0] STARTERS [8] = '{
		CH_S_LO, CH_S_UP, CH_C_LO, CH_C_UP, CH_O_LO, CH_O_UP, CH_G_LO, CH_G_UP
	};

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic [7:0] in_byte     = 8'h00;
	logic       end_of_text = 1'b0;
	logic       out_ready   = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       run_last;
	logic       text_last;

	int         mismatches;
	int         beats_owed;
	int         in_idle  = 35;
	int         out_idle = 49;
	int         sent     = 0;
	logic [7:0] text_q [$];

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= out_idle);
	end

	utf8_digraph_fold_stream_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.text_last   (text_last)
	);

	u8df_checker i_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.text_last   (text_last),
		.mismatches  (mismatches),
		.beats_owed  (beats_owed)
	);

	function automatic int len_of(input logic [CODE_W-1:0] c);
		if (c < 21'h80) begin
			return 1;
		end else if (c < 21'h800) begin
			return 2;
		end else if (c < 21'h10000) begin
			return 3;
		end
		return 4;
	endfunction

	function automatic logic [CODE_W-1:0] pick_follower();
		logic [31:0] r;
		r = $urandom;
		case (r[2:0])
			3'd0, 3'd1: return {13'd0, CH_H_LO};
			3'd2: return {13'd0, CH_H_UP};
			3'd3, 3'd4, 3'd5: return APOS[$urandom_range(N_APOS - 1)];
			default: return {5'd0, r[31:16]};
		endcase
	endfunction

	task automatic add_char(input logic [CODE_W-1:0] c, input int len);
		case (len)
			1: text_q.push_back({1'b0, c[6:0]});
			2: begin
				text_q.push_back({3'b110, c[10:6]});
				text_q.push_back({2'b10, c[5:0]});
			end
			3: begin
				text_q.push_back({4'b1110, c[15:12]});
				text_q.push_back({2'b10, c[11:6]});
				text_q.push_back({2'b10, c[5:0]});
			end
			default: begin
				text_q.push_back({5'b11110, c[20:18]});
				text_q.push_back({2'b10, c[17:12]});
				text_q.push_back({2'b10, c[11:6]});
				text_q.push_back({2'b10, c[5:0]});
			end
		endcase
	endtask

	task automatic add_token;
		logic [31:0]       r;
		logic [CODE_W-1:0] c;
		int                kind;
		int                len;
		int                keep;
		kind = $urandom_range(99);
		r    = $urandom;
		if (kind < 35) begin
			text_q.push_back(STARTERS[r[2:0]]);
			c = pick_follower();
			if (r[3] && r[4]) begin
				add_char(c, $urandom_range(len_of(c), 4));
			end else begin
				add_char(c, len_of(c));
			end
		end else if (kind < 55) begin
			text_q.push_back({1'b0, r[6:0]});
		end else if (kind < 68) begin
			add_char(r[CODE_W-1:0], $urandom_range(2, 4));
		end else if (kind < 78) begin
			c = pick_follower();
			add_char(c, len_of(c));
		end else begin
			case (r[1:0])
				2'd0: text_q.push_back(r[15:8]);
				2'd1: text_q.push_back({5'b11111, r[10:8]});
				2'd2: begin
					len  = $urandom_range(2, 4);
					keep = $urandom_range(1, len - 1);
					add_char(r[CODE_W-1:0], len);
					repeat (len - keep) text_q.delete(text_q.size() - 1);
					if (r[31]) begin
						text_q.push_back({1'b0, r[30:24]});
					end
				end
				default: text_q.push_back({2'b10, r[13:8]});
			endcase
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic e);
		logic took;
		if (sent < 160) begin
			in_idle  = 35;
			out_idle = 49;
		end else if (sent < 310) begin
			in_idle  = 49;
			out_idle = 35;
		end else begin
			in_idle  = 0;
			out_idle = 0;
		end
		while ($urandom_range(99) < in_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		in_byte     <= b;
		end_of_text <= e;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		sent++;
	endtask

	task automatic send_text;
		for (int i = 0; i < text_q.size(); i++) begin
			send_byte(text_q[i], i == text_q.size() - 1);
		end
		text_q.delete();
	endtask

	task automatic drain_wait;
		in_valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (beats_owed != 0);
		@(posedge clk);
	endtask

	initial begin
		#1000000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic paused;
		paused = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		text_q = '{8'h00, CH_S_LO, CH_H_LO};
		send_text();
		text_q = '{CH_S_UP, CH_H_UP, CH_C_UP, CH_H_LO};
		send_text();
		text_q = '{CH_O_LO, 8'h27, CH_G_UP, 8'hE2, 8'h80, 8'hB2};
		send_text();
		text_q = '{CH_C_LO, 8'hC1, 8'hA8};
		send_text();
		text_q = '{8'hFF, 8'h80, CH_G_LO};
		send_text();
		text_q = '{8'hE2, 8'h80, 8'h41};
		send_text();
		text_q = '{8'hF0, 8'h90, 8'h80};
		send_text();
		text_q = '{CH_O_UP};
		send_text();
		drain_wait();

		while (sent < 420) begin
			if (!paused && sent >= 240) begin
				drain_wait();
				paused = 1'b1;
			end
			repeat ($urandom_range(1, 6)) add_token();
			send_text();
		end

		drain_wait();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && beats_owed == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/u8df_pkg.sv
sv/u8df_front.sv
sv/u8df_queue.sv
sv/u8df_back.sv
sv/utf8_digraph_fold_stream_top.sv
dv/u8df_checker.sv
dv/testbench.sv
